/* rtl/cbfs_pkg.sv */
// Shared constants, codes and controller/datapath link types for the clipped blit frame store.
`default_nettype none

package cbfs_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;

	localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int XW     = $clog2(MAX_WIDTH + 1);
	localparam int YW     = $clog2(MAX_HEIGHT + 1);
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	typedef enum logic [1:0] {
		CMD_PLACE   = 2'd0,
		CMD_FILL    = 2'd1,
		CMD_REPLACE = 2'd2,
		CMD_READ    = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 3'd0,
		REG_FRAME_HEIGHT = 3'd1,
		REG_PLACE_X      = 3'd2,
		REG_PLACE_Y      = 3'd3,
		REG_WINDOW_X     = 3'd4,
		REG_WINDOW_Y     = 3'd5,
		REG_WINDOW_W     = 3'd6,
		REG_WINDOW_H     = 3'd7
	} reg_idx_t;

	// controller to datapath
	typedef struct packed {
		logic latch;       // capture the accepted item
		logic clear_wr;    // write zero at the clear pointer and advance it
		logic place_calc;  // work out clip and address of a placed pixel
		logic place_wr;    // write the placed pixel if it landed
		logic read_issue;  // read one pixel for the read command
		logic sweep_rd;    // read the pixel under the sweep pointer
		logic sweep_wr;    // conditional write and advance of the sweep pointer
		logic load_result; // move the result into the output register
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;
		logic sweep_last;
		logic frame_empty;
	} stat_t;

endpackage

`default_nettype wire

/* rtl/cbfs_ctrl.sv */
// Controller state machine: clearing pass, command sequencing and output beat handshake.
`default_nettype none

module cbfs_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	output logic                 item_stall,
	input  wire logic [1:0]      cmd,
	output logic                 result_valid,
	input  wire logic            result_stall,
	output cbfs_pkg::ctl_t       ctl,
	input  wire cbfs_pkg::stat_t stat
);
	import cbfs_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_PLACE_CALC,
		S_PLACE_WR,
		S_READ,
		S_SWEEP_RD,
		S_SWEEP_WR,
		S_RESULT
	} state_t;

	state_t state_q;
	logic   valid_q;
	logic   accept;
	logic   out_free;

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = valid_q;
	assign accept       = item_valid && (state_q == S_IDLE);
	assign out_free     = !valid_q || !result_stall;

	always_comb begin
		ctl             = '0;
		ctl.latch       = accept;
		ctl.clear_wr    = (state_q == S_CLEAR);
		ctl.place_calc  = (state_q == S_PLACE_CALC);
		ctl.place_wr    = (state_q == S_PLACE_WR);
		ctl.read_issue  = (state_q == S_READ);
		ctl.sweep_rd    = (state_q == S_SWEEP_RD);
		ctl.sweep_wr    = (state_q == S_SWEEP_WR);
		ctl.load_result = (state_q == S_RESULT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			valid_q <= 1'b0;
		end else begin
			// raise the beat on a load, drop it once taken
			if (ctl.load_result)
				valid_q <= 1'b1;
			else if (!result_stall)
				valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					if (stat.clear_last)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (item_valid) begin
						unique case (cmd_t'(cmd))
							CMD_PLACE: state_q <= S_PLACE_CALC;
							CMD_READ:  state_q <= S_READ;
							CMD_FILL, CMD_REPLACE:
								state_q <= stat.frame_empty ? S_RESULT : S_SWEEP_RD;
						endcase
					end
				end
				S_PLACE_CALC: state_q <= S_PLACE_WR;
				S_PLACE_WR:   state_q <= S_RESULT;
				S_READ:       state_q <= S_RESULT;
				S_SWEEP_RD:   state_q <= S_SWEEP_WR;
				S_SWEEP_WR: begin
					state_q <= stat.sweep_last ? S_RESULT : S_SWEEP_RD;
				end
				S_RESULT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/cbfs_dpath.sv */
// Datapath: configuration registers, clip arithmetic, sweep pointers, frame memory and result register.
`default_nettype none

module cbfs_dpath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic [cbfs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [cbfs_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic [1:0]                          cmd,
	input  wire logic [11:0]                         pos_col,
	input  wire logic [11:0]                         pos_row,
	input  wire logic [31:0]                         pixel_color,
	input  wire logic [31:0]                         match_color,
	input  wire cbfs_pkg::ctl_t                      ctl,
	output cbfs_pkg::stat_t                          stat,
	output logic [31:0]                              read_value,
	output logic                                     pixel_written,
	output logic                                     read_outside
);
	import cbfs_pkg::*;

	// configuration
	logic [8:0]         frame_width_q;
	logic [8:0]         frame_height_q;
	logic signed [12:0] place_x_q;
	logic signed [12:0] place_y_q;
	logic [11:0]        window_x_q;
	logic [11:0]        window_y_q;
	logic [12:0]        window_w_q;
	logic [12:0]        window_h_q;

	// captured item
	cmd_t        cmd_q;
	logic [11:0] col_q;
	logic [11:0] row_q;
	logic [31:0] color_q;
	logic [31:0] match_q;

	// per-item flags and pointers
	logic              wrote_q;
	logic              outside_q;
	logic [ADDR_W-1:0] place_addr_q;
	logic [ADDR_W-1:0] clr_q;
	logic [XW-1:0]     x_q;
	logic [YW-1:0]     y_q;

	// frame memory
	logic [31:0]       mem [DEPTH];
	logic [31:0]       rdata_q;
	logic              mem_we;
	logic              mem_re;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	logic [31:0]       wdata;

	// derived values
	logic [XW-1:0]      fw_used;
	logic [YW-1:0]      fh_used;
	logic [13:0]        win_x_end;
	logic [13:0]        win_y_end;
	logic               in_window;
	logic signed [13:0] dx;
	logic signed [13:0] dy;
	logic               in_frame;
	logic               read_out;
	logic [ADDR_W-1:0]  read_addr;
	logic [ADDR_W-1:0]  sweep_addr;
	logic [ADDR_W-1:0]  dest_addr;
	logic [XW-1:0]      x_nxt;
	logic [YW-1:0]      y_nxt;
	logic               row_end;
	logic               sweep_hit;

	assign fw_used = (13'(frame_width_q) > 13'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(frame_width_q);
	assign fh_used = (13'(frame_height_q) > 13'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT)
		: YW'(frame_height_q);

	assign win_x_end = 14'(window_x_q) + 14'(window_w_q);
	assign win_y_end = 14'(window_y_q) + 14'(window_h_q);
	assign in_window = (col_q >= window_x_q) && (14'(col_q) < win_x_end)
		&& (row_q >= window_y_q) && (14'(row_q) < win_y_end);

	assign dx = 14'(place_x_q) + signed'({2'b00, 12'(col_q - window_x_q)});
	assign dy = 14'(place_y_q) + signed'({2'b00, 12'(row_q - window_y_q)});
	assign in_frame = !dx[13] && !dy[13]
		&& ($unsigned(dx) < 14'(fw_used)) && ($unsigned(dy) < 14'(fh_used));
	assign dest_addr = ADDR_W'(dy[ROW_W-1:0]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(dx[COL_W-1:0]);

	assign read_out  = !((13'(col_q) < 13'(fw_used)) && (13'(row_q) < 13'(fh_used)));
	assign read_addr = ADDR_W'(row_q[ROW_W-1:0]) * ADDR_W'(MAX_WIDTH)
		+ ADDR_W'(col_q[COL_W-1:0]);

	assign sweep_addr = ADDR_W'(y_q[ROW_W-1:0]) * ADDR_W'(MAX_WIDTH)
		+ ADDR_W'(x_q[COL_W-1:0]);
	assign x_nxt   = x_q + 1'b1;
	assign y_nxt   = y_q + 1'b1;
	assign row_end = (x_nxt == fw_used);
	assign sweep_hit = (cmd_q == CMD_FILL) || (rdata_q == match_q);

	assign stat.clear_last  = (clr_q == ADDR_W'(DEPTH - 1));
	assign stat.sweep_last  = row_end && (y_nxt == fh_used);
	assign stat.frame_empty = (fw_used == '0) || (fh_used == '0);

	// memory port selection
	always_comb begin
		mem_we = 1'b0;
		waddr  = sweep_addr;
		wdata  = color_q;
		priority if (ctl.clear_wr) begin
			mem_we = 1'b1;
			waddr  = clr_q;
			wdata  = '0;
		end else if (ctl.place_wr) begin
			mem_we = wrote_q;
			waddr  = place_addr_q;
		end else if (ctl.sweep_wr) begin
			mem_we = sweep_hit;
		end else begin
			mem_we = 1'b0;
		end
	end

	assign mem_re = ctl.read_issue || ctl.sweep_rd;
	assign raddr  = ctl.read_issue ? read_addr : sweep_addr;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[waddr] <= wdata;
		if (mem_re)
			rdata_q <= mem[raddr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= 9'd256;
			frame_height_q <= 9'd256;
			place_x_q      <= '0;
			place_y_q      <= '0;
			window_x_q     <= '0;
			window_y_q     <= '0;
			window_w_q     <= '0;
			window_h_q     <= '0;
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[8:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[8:0];
				REG_PLACE_X:      place_x_q      <= signed'(cfg_data[12:0]);
				REG_PLACE_Y:      place_y_q      <= signed'(cfg_data[12:0]);
				REG_WINDOW_X:     window_x_q     <= cfg_data[11:0];
				REG_WINDOW_Y:     window_y_q     <= cfg_data[11:0];
				REG_WINDOW_W:     window_w_q     <= cfg_data[12:0];
				REG_WINDOW_H:     window_h_q     <= cfg_data[12:0];
			endcase
		end
	end

	// control pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			x_q   <= '0;
			y_q   <= '0;
		end else begin
			if (ctl.clear_wr)
				clr_q <= clr_q + 1'b1;
			if (ctl.latch) begin
				x_q <= '0;
				y_q <= '0;
			end else if (ctl.sweep_wr) begin
				if (row_end) begin
					x_q <= '0;
					y_q <= y_nxt;
				end else begin
					x_q <= x_nxt;
				end
			end
		end
	end

	// item capture, flags and result register
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q     <= cmd_t'(cmd);
			col_q     <= pos_col;
			row_q     <= pos_row;
			color_q   <= pixel_color;
			match_q   <= match_color;
			wrote_q   <= 1'b0;
			outside_q <= 1'b0;
		end
		if (ctl.place_calc) begin
			wrote_q      <= in_window && in_frame;
			place_addr_q <= dest_addr;
		end
		if (ctl.read_issue)
			outside_q <= read_out;
		if (ctl.load_result) begin
			read_value    <= ((cmd_q == CMD_READ) && !outside_q) ? rdata_q : '0;
			pixel_written <= wrote_q;
			read_outside  <= outside_q;
		end
	end

endmodule

`default_nettype wire

/* rtl/clipped_blit_frame_store.sv */
// Top level of the clipped blit frame store: joins controller and datapath.
//
// Item channel (item_valid/item_stall) carries one command per beat: place a
// source pixel (clipped to the source window and to the frame), fill the frame,
// replace a colour across the frame, or read one pixel. Every item gives exactly
// one beat on the result channel (result_valid/result_stall).
// The configuration port (cfg_wr_en, cfg_index, cfg_data) writes one register
// per cycle and is taken at any time; change it only while no item is in flight.
// A place item works out the clip and address, then writes the pixel if it
// landed; a read issues one read of the frame memory, which is registered.
// Fill and replace sweep the frame in use pixel by pixel (read, then
// conditional write). Every item ends by loading the output register.
// After reset the block runs a clearing pass over all MAX_WIDTH*MAX_HEIGHT words
// with item_stall high; configuration writes are accepted. A result waits in the
// output register while result_stall is high; the next item is still accepted
// and held until the register frees.
`default_nettype none

module clipped_blit_frame_store (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic [cbfs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [cbfs_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                item_valid,
	output logic                                     item_stall,
	input  wire logic [1:0]                          cmd,
	input  wire logic [11:0]                         pos_col,
	input  wire logic [11:0]                         pos_row,
	input  wire logic [31:0]                         pixel_color,
	input  wire logic [31:0]                         match_color,
	output logic                                     result_valid,
	input  wire logic                                result_stall,
	output logic [31:0]                              read_value,
	output logic                                     pixel_written,
	output logic                                     read_outside
);
	import cbfs_pkg::*;

	ctl_t  ctl;
	stat_t stat;

	cbfs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.cmd          (cmd),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.ctl          (ctl),
		.stat         (stat)
	);

	cbfs_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.pos_col       (pos_col),
		.pos_row       (pos_row),
		.pixel_color   (pixel_color),
		.match_color   (match_color),
		.ctl           (ctl),
		.stat          (stat),
		.read_value    (read_value),
		.pixel_written (pixel_written),
		.read_outside  (read_outside)
	);

endmodule

`default_nettype wire

/* tb/sv/tb_clipped_blit_frame_store.sv */
// Self-checking testbench for the clipped blit frame store: directed table, then random phases.
`default_nettype none

module tb_clipped_blit_frame_store;
	timeunit 1ns;
	timeprecision 1ps;

	import cbfs_pkg::*;

	localparam int CYCLE_LIMIT  = 3_000_000;
	localparam int PHASES       = 12;
	localparam int PHASE_BEATS  = 125;
	localparam int HOLD_CYCLES  = 600;
	localparam int SETTLE       = 20;

	typedef struct packed {
		logic [31:0] read_value;
		logic        pixel_written;
		logic        read_outside;
	} blit_result_t;

	typedef struct packed {
		bit           is_reg;
		reg_idx_t     ridx;
		logic [12:0]  rval;
		cmd_t         op;
		logic [11:0]  col;
		logic [11:0]  row;
		logic [31:0]  color;
		logic [31:0]  match;
		bit           typed;
		blit_result_t want;
	} plan_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  item_valid;
	logic                  item_stall;
	cmd_t                  cmd;
	logic [11:0]           pos_col;
	logic [11:0]           pos_row;
	logic [31:0]           pixel_color;
	logic [31:0]           match_color;
	logic                  result_valid;
	logic                  result_stall;
	logic [31:0]           read_value;
	logic                  pixel_written;
	logic                  read_outside;

	// typed-in expectation travelling with the beat on the item channel
	logic                  cur_typed;
	blit_result_t          cur_want;

	// mirror of the frame and of the registers
	bit [31:0]    frame_mirror [DEPTH];
	int           frame_w_cfg = 256;
	int           frame_h_cfg = 256;
	int           place_x_cfg = 0;
	int           place_y_cfg = 0;
	int           win_x_cfg   = 0;
	int           win_y_cfg   = 0;
	int           win_w_cfg   = 0;
	int           win_h_cfg   = 0;

	blit_result_t pending_results [$];
	plan_row_t    plan [$];

	int  error_count   = 0;
	int  beat_count    = 0;
	int  landed_count  = 0;
	int  outside_count = 0;
	int  sweep_count   = 0;
	int  setting_count = 0;
	int  burst_left    = 0;
	int  cycle_count;
	bit  long_hold_req = 0;

	clipped_blit_frame_store DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.cmd           (cmd),
		.pos_col       (pos_col),
		.pos_row       (pos_row),
		.pixel_color   (pixel_color),
		.match_color   (match_color),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.read_value    (read_value),
		.pixel_written (pixel_written),
		.read_outside  (read_outside)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic blit_result_t blit_model_step(cmd_t op, logic [11:0] col,
			logic [11:0] row, logic [31:0] color, logic [31:0] match);
		blit_result_t res;
		int fw, fh, c, r, dx, dy, a;
		res = '0;
		fw = (frame_w_cfg > MAX_WIDTH) ? MAX_WIDTH : frame_w_cfg;
		fh = (frame_h_cfg > MAX_HEIGHT) ? MAX_HEIGHT : frame_h_cfg;
		c = col;
		r = row;
		case (op)
		CMD_PLACE: begin
			if (c >= win_x_cfg && c < win_x_cfg + win_w_cfg &&
			    r >= win_y_cfg && r < win_y_cfg + win_h_cfg) begin
				dx = place_x_cfg + (c - win_x_cfg);
				dy = place_y_cfg + (r - win_y_cfg);
				if (dx >= 0 && dy >= 0 && dx < fw && dy < fh) begin
					frame_mirror[dy * MAX_WIDTH + dx] = color;
					res.pixel_written = 1'b1;
				end
			end
		end
		CMD_FILL, CMD_REPLACE: begin
			for (int y = 0; y < fh; y++) begin
				for (int x = 0; x < fw; x++) begin
					a = y * MAX_WIDTH + x;
					if (op == CMD_FILL || frame_mirror[a] == match)
						frame_mirror[a] = color;
				end
			end
		end
		default: begin
			if (c < fw && r < fh)
				res.read_value = frame_mirror[r * MAX_WIDTH + c];
			else
				res.read_outside = 1'b1;
		end
		endcase
		return res;
	endfunction

	function automatic plan_row_t item_row(cmd_t op, int col, int row, logic [31:0] color,
			logic [31:0] match, bit typed, logic [31:0] rv, bit pw, bit ro);
		plan_row_t p;
		p = '0;
		p.op    = op;
		p.col   = col[11:0];
		p.row   = row[11:0];
		p.color = color;
		p.match = match;
		p.typed = typed;
		p.want  = '{read_value: rv, pixel_written: pw, read_outside: ro};
		return p;
	endfunction

	function automatic plan_row_t reg_row(reg_idx_t idx, int val);
		plan_row_t p;
		p = '0;
		p.is_reg = 1'b1;
		p.ridx   = idx;
		p.rval   = val[12:0];
		return p;
	endfunction

	task automatic flag_error(string what);
		$display("ERROR at %0t ns: %s", $time, what);
		error_count++;
	endtask

	task automatic write_reg(reg_idx_t idx, logic [12:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
		REG_FRAME_WIDTH:  frame_w_cfg = val[8:0];
		REG_FRAME_HEIGHT: frame_h_cfg = val[8:0];
		REG_PLACE_X:      place_x_cfg = $signed(val);
		REG_PLACE_Y:      place_y_cfg = $signed(val);
		REG_WINDOW_X:     win_x_cfg   = val[11:0];
		REG_WINDOW_Y:     win_y_cfg   = val[11:0];
		REG_WINDOW_W:     win_w_cfg   = val;
		REG_WINDOW_H:     win_h_cfg   = val;
		default: ;
		endcase
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_beat(plan_row_t p);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 200)
			                                          : $urandom_range(1, 24);
		end
		burst_left--;
		item_valid  <= 1'b1;
		cmd         <= p.op;
		pos_col     <= p.col;
		pos_row     <= p.row;
		pixel_color <= p.color;
		match_color <= p.match;
		cur_typed   <= p.typed;
		cur_want    <= p.want;
		do @(posedge clk); while (item_stall !== 1'b0);
	endtask

	// hold off until every expected result is back and the block has settled;
	// wait for a clock edge first so the last accepted beat is already queued
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	always @(posedge clk) begin
		blit_result_t want, got;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (pending_results.size() == 0) begin
					flag_error("result beat with nothing expected");
				end else begin
					want = pending_results.pop_front();
					if (read_value !== want.read_value)
						flag_error($sformatf("read_value %h, want %h",
							read_value, want.read_value));
					if (pixel_written !== want.pixel_written)
						flag_error($sformatf("pixel_written %b, want %b",
							pixel_written, want.pixel_written));
					if (read_outside !== want.read_outside)
						flag_error($sformatf("read_outside %b, want %b",
							read_outside, want.read_outside));
				end
			end
			if (item_valid && !item_stall) begin
				got = blit_model_step(cmd, pos_col, pos_row, pixel_color, match_color);
				pending_results.push_back(cur_typed ? cur_want : got);
				beat_count++;
				landed_count  += got.pixel_written;
				outside_count += got.read_outside;
				if (cmd == CMD_FILL || cmd == CMD_REPLACE)
					sweep_count++;
			end
		end
	end

	// receiver: segments of differing stall density, plus one long hold-off
	initial begin
		int seg_len, mode;
		result_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			seg_len = $urandom_range(20, 200);
			mode    = $urandom_range(0, 3);
			for (int k = 0; k < seg_len; k++) begin
				if (long_hold_req) begin
					long_hold_req = 1'b0;
					result_stall <= 1'b1;
					repeat (HOLD_CYCLES) @(posedge clk);
				end
				case (mode)
				0:       result_stall <= 1'b0;
				1:       result_stall <= ($urandom_range(0, 99) < 30);
				2:       result_stall <= ($urandom_range(0, 99) < 80);
				default: result_stall <= k[0];
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding",
			cycle_count, pending_results.size());
		$display("tb_clipped_blit_frame_store: errors");
		$finish;
	end

	initial begin
		int          fwv, fhv, uw, uh, wxv, wyv, wwv, whv, pxv, pyv, c, r, pick, lim;
		bit          wide, prev_reg;
		logic [31:0] pal [4];
		logic [31:0] colour;
		plan_row_t   p;

		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_index   = REG_FRAME_WIDTH;
		cfg_data    = '0;
		item_valid  = 1'b0;
		cmd         = CMD_PLACE;
		pos_col     = '0;
		pos_row     = '0;
		pixel_color = '0;
		match_color = '0;
		cur_typed   = 1'b0;
		cur_want    = '0;

		// after reset: full frame, empty window
		plan.push_back(item_row(CMD_READ,  0,   0,    0, 0, 1, 0, 0, 0));
		plan.push_back(item_row(CMD_READ,  255, 255,  0, 0, 1, 0, 0, 0));
		plan.push_back(item_row(CMD_READ,  256, 0,    0, 0, 1, 0, 0, 1));
		plan.push_back(item_row(CMD_READ,  0,   4095, 0, 0, 1, 0, 0, 1));
		plan.push_back(item_row(CMD_PLACE, 0,   0,    32'hFFFF_FFFF, 0, 1, 0, 0, 0));
		plan.push_back(item_row(CMD_FILL,  0,   0,    32'hA5A5_5A5A, 0, 1, 0, 0, 0));
		plan.push_back(item_row(CMD_READ,  255, 255,  0, 0, 1, 32'hA5A5_5A5A, 0, 0));
		// one-pixel window at the far corner of the source space
		plan.push_back(reg_row(REG_FRAME_WIDTH,  4));
		plan.push_back(reg_row(REG_FRAME_HEIGHT, 3));
		plan.push_back(reg_row(REG_WINDOW_X,     4095));
		plan.push_back(reg_row(REG_WINDOW_Y,     4095));
		plan.push_back(reg_row(REG_WINDOW_W,     1));
		plan.push_back(reg_row(REG_WINDOW_H,     1));
		plan.push_back(reg_row(REG_PLACE_X,      3));
		plan.push_back(reg_row(REG_PLACE_Y,      2));
		plan.push_back(item_row(CMD_PLACE, 4095, 4095, 32'h1234_5678, 0, 1, 0, 1, 0));
		plan.push_back(item_row(CMD_READ,  3,    2,    0, 0, 1, 32'h1234_5678, 0, 0));
		plan.push_back(item_row(CMD_PLACE, 4094, 4095, 32'h0000_0001, 0, 1, 0, 0, 0));
		plan.push_back(item_row(CMD_FILL,  0,    0,    0, 0, 1, 0, 0, 0));
		plan.push_back(item_row(CMD_READ,  3,    2,    0, 0, 1, 0, 0, 0));
		plan.push_back(item_row(CMD_READ,  4,    0,    0, 0, 1, 0, 0, 1));
		// oversized width acts as the maximum; pixels beyond the small fill keep their value
		plan.push_back(reg_row(REG_FRAME_WIDTH,  511));
		plan.push_back(reg_row(REG_FRAME_HEIGHT, 1));
		plan.push_back(item_row(CMD_READ,    255, 0, 0, 0, 1, 32'hA5A5_5A5A, 0, 0));
		plan.push_back(item_row(CMD_READ,    0,   1, 0, 0, 1, 0, 0, 1));
		plan.push_back(item_row(CMD_REPLACE, 0,   0, 32'hFFFF_FFFF, 32'hA5A5_5A5A,
			1, 0, 0, 0));
		plan.push_back(item_row(CMD_READ,    200, 0, 0, 0, 0, 0, 0, 0));
		plan.push_back(item_row(CMD_READ,    0,   0, 0, 0, 0, 0, 0, 0));
		// placement offsets at both extremes push the pixel off the frame
		plan.push_back(reg_row(REG_PLACE_X,  -4096));
		plan.push_back(reg_row(REG_PLACE_Y,  4095));
		plan.push_back(reg_row(REG_WINDOW_X, 0));
		plan.push_back(reg_row(REG_WINDOW_Y, 0));
		plan.push_back(reg_row(REG_WINDOW_W, 4096));
		plan.push_back(reg_row(REG_WINDOW_H, 8191));
		plan.push_back(item_row(CMD_PLACE, 0,    0,    32'h0BAD_F00D, 0, 1, 0, 0, 0));
		plan.push_back(item_row(CMD_PLACE, 4095, 4095, 32'h0BAD_F00D, 0, 1, 0, 0, 0));
		// empty frame
		plan.push_back(reg_row(REG_FRAME_WIDTH,  0));
		plan.push_back(reg_row(REG_FRAME_HEIGHT, 256));
		plan.push_back(reg_row(REG_PLACE_X,      0));
		plan.push_back(reg_row(REG_PLACE_Y,      0));
		plan.push_back(item_row(CMD_READ,  0, 0, 0, 0, 1, 0, 0, 1));
		plan.push_back(item_row(CMD_PLACE, 0, 0, 32'h5555_AAAA, 0, 1, 0, 0, 0));
		plan.push_back(item_row(CMD_FILL,  0, 0, 32'h0000_0077, 0, 1, 0, 0, 0));
		plan.push_back(reg_row(REG_FRAME_WIDTH,  2));
		plan.push_back(reg_row(REG_FRAME_HEIGHT, 2));
		plan.push_back(item_row(CMD_REPLACE, 0, 0, 32'hCAFE_0001, 0, 0, 0, 0, 0));
		plan.push_back(item_row(CMD_READ,    1, 1, 0, 0, 0, 0, 0, 0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		prev_reg = 1'b0;
		foreach (plan[i]) begin
			if (plan[i].is_reg) begin
				if (!prev_reg)
					drain();
				write_reg(plan[i].ridx, plan[i].rval);
				setting_count++;
			end else begin
				send_beat(plan[i]);
			end
			prev_reg = plan[i].is_reg;
		end
		drain();

		long_hold_req = 1'b1;
		for (int phase = 0; phase < PHASES; phase++) begin
			wide = (phase % 4 == 3);
			if (wide) begin
				fwv = ($urandom_range(0, 1) == 0) ? 256 : $urandom_range(64, 511);
				fhv = ($urandom_range(0, 1) == 0) ? 256 : $urandom_range(64, 511);
			end else begin
				fwv = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 32);
				fhv = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 32);
			end
			uw  = (fwv > MAX_WIDTH) ? MAX_WIDTH : fwv;
			uh  = (fhv > MAX_HEIGHT) ? MAX_HEIGHT : fhv;
			wxv = ($urandom_range(0, 4) == 0) ? 4095 : $urandom_range(0, 4095);
			wyv = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 4095);
			wwv = wide ? $urandom_range(1, 300) : $urandom_range(1, 48);
			whv = wide ? $urandom_range(1, 300) : $urandom_range(1, 48);
			pick = $urandom_range(0, 9);
			if (pick == 0) wwv = 8191;
			if (pick == 1) whv = 4096;
			if (pick == 2) wwv = 0;
			pxv = $urandom_range(0, uw + 16) - 12;
			pyv = $urandom_range(0, uh + 16) - 12;
			pick = $urandom_range(0, 9);
			if (pick == 0) pxv = -4096;
			if (pick == 1) pyv = 4095;
			write_reg(REG_FRAME_WIDTH,  fwv[12:0]);
			write_reg(REG_FRAME_HEIGHT, fhv[12:0]);
			write_reg(REG_PLACE_X,      pxv[12:0]);
			write_reg(REG_PLACE_Y,      pyv[12:0]);
			write_reg(REG_WINDOW_X,     wxv[12:0]);
			write_reg(REG_WINDOW_Y,     wyv[12:0]);
			write_reg(REG_WINDOW_W,     wwv[12:0]);
			write_reg(REG_WINDOW_H,     whv[12:0]);
			setting_count++;
			pal[0] = 32'h0;
			pal[1] = 32'hFFFF_FFFF;
			pal[2] = 32'h00FF_00FF;
			pal[3] = $urandom;

			for (int k = 0; k < PHASE_BEATS; k++) begin
				pick   = $urandom_range(0, 99);
				colour = ($urandom_range(0, 1) == 0) ? pal[$urandom_range(0, 3)] : $urandom;
				if (!wide && pick < 4) begin
					p = item_row(CMD_FILL, $urandom, $urandom, colour, $urandom, 0, 0, 0, 0);
				end else if (!wide && pick < 8) begin
					p = item_row(CMD_REPLACE, $urandom, $urandom, colour,
						pal[$urandom_range(0, 3)], 0, 0, 0, 0);
				end else if (pick < 60) begin
					// mostly inside the window, with a pixel of margin on each side
					lim = (wwv > 300) ? 300 : wwv;
					c   = wxv + $urandom_range(0, lim + 1) - 1;
					lim = (whv > 300) ? 300 : whv;
					r   = wyv + $urandom_range(0, lim + 1) - 1;
					if (c < 0) c = 0;
					if (r < 0) r = 0;
					p = item_row(CMD_PLACE, c, r, colour, $urandom, 0, 0, 0, 0);
				end else if (pick < 70) begin
					p = item_row(CMD_PLACE, $urandom, $urandom, colour, $urandom, 0, 0, 0, 0);
				end else if (pick < 92) begin
					p = item_row(CMD_READ, $urandom_range(0, uw + 1),
						$urandom_range(0, uh + 1), $urandom, $urandom, 0, 0, 0, 0);
				end else begin
					p = item_row(CMD_READ, $urandom, $urandom, $urandom, $urandom, 0, 0, 0, 0);
				end
				send_beat(p);
			end
			drain();
		end

		if (pending_results.size() != 0)
			flag_error($sformatf("%0d expected results never arrived",
				pending_results.size()));
		$display("covered %0d beats under %0d register settings in %0d cycles",
			beat_count, setting_count, cycle_count);
		$display("%0d placed pixels landed, %0d reads off the frame, %0d fill/replace sweeps",
			landed_count, outside_count, sweep_count);
		if (error_count == 0)
			$display("tb_clipped_blit_frame_store: clean");
		else
			$display("tb_clipped_blit_frame_store: errors");
		$finish;
	end

endmodule

`default_nettype wire
